// ----- rtl/core/ps2mct_pkg.sv -----
// Package for the PS/2 mouse cursor tracker: screen geometry, widths and the
// packet word passed from the byte assembler to the cursor update stage.
// No dependencies.
`default_nettype none

package ps2mct_pkg;

	// Screen geometry
	localparam int SCREEN_WIDTH  = 1024;
	localparam int SCREEN_HEIGHT = 768;

	// Position register width covers the larger screen axis
	localparam int SCREEN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int POS_W      = (SCREEN_MAX > 2) ? $clog2(SCREEN_MAX) : 1;
	// Signed sum width: position plus a signed byte, with headroom
	localparam int SUM_W      = ((POS_W > 8) ? POS_W : 8) + 2;

	// Field widths
	localparam int BYTE_W   = 8;
	localparam int LIMIT_W  = 7;
	localparam int COORD_W  = 10;
	localparam int BUTTON_W = 3;

	// Stream word widths
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	// First byte of a packet must carry this sync bit
	localparam int SYNC_BIT = 3;

	// Reset values
	localparam logic [LIMIT_W-1:0] JUMP_LIMIT_RESET = LIMIT_W'(50);
	localparam logic [POS_W-1:0]   POS_X_RESET      = POS_W'(SCREEN_WIDTH / 2);
	localparam logic [POS_W-1:0]   POS_Y_RESET      = POS_W'(SCREEN_HEIGHT / 2);

	// Packet queue geometry
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// One assembled packet
	typedef struct packed {
		logic [BUTTON_W-1:0]      buttons;
		logic signed [BYTE_W-1:0] dx;
		logic signed [BYTE_W-1:0] dy;
	} pkt_t;

endpackage

`default_nettype wire

// ----- rtl/core/ps2mct_front.sv -----
// Byte assembler: tracks the position of each byte inside a packet, drops
// bytes that cannot start a packet and emits complete packets.
// Depends on ps2mct_pkg.
`default_nettype none

module ps2mct_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              byte_valid,
	input  wire logic [ps2mct_pkg::BYTE_W-1:0]     byte_data,
	output ps2mct_pkg::pkt_t                       pkt,
	output logic                                   pkt_push
);

	typedef enum logic [1:0] {
		ST_FIRST,
		ST_SECOND,
		ST_THIRD
	} state_t;

	state_t                                state_q;
	logic [ps2mct_pkg::BUTTON_W-1:0]       buttons_q;
	logic [ps2mct_pkg::BYTE_W-1:0]         dx_q;

	// Packet is complete on the third word
	assign pkt_push    = byte_valid && (state_q == ST_THIRD);
	assign pkt.buttons = buttons_q;
	assign pkt.dx      = dx_q;
	assign pkt.dy      = byte_data;

	// Advance through the packet, drop first words without the sync bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FIRST;
			buttons_q <= '0;
			dx_q      <= '0;
		end else if (byte_valid) begin
			case (state_q)
				ST_FIRST: begin
					if (byte_data[ps2mct_pkg::SYNC_BIT]) begin
						buttons_q <= byte_data[ps2mct_pkg::BUTTON_W-1:0];
						state_q   <= ST_SECOND;
					end
				end
				ST_SECOND: begin
					dx_q    <= byte_data;
					state_q <= ST_THIRD;
				end
				ST_THIRD: begin
					state_q <= ST_FIRST;
				end
				default: begin
					state_q <= ST_FIRST;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ps2mct_queue.sv -----
// Short packet queue between the byte assembler and the cursor update stage.
// Depends on ps2mct_pkg.
`default_nettype none

module ps2mct_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  ps2mct_pkg::pkt_t        push_pkt,
	output logic                    full,
	output logic                    pop_valid,
	input  wire logic               pop,
	output ps2mct_pkg::pkt_t        pop_pkt
);

	ps2mct_pkg::pkt_t                   entry_q [ps2mct_pkg::QDEPTH];
	logic [ps2mct_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [ps2mct_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [ps2mct_pkg::QCNT_W-1:0]      count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full      = (count_q == ps2mct_pkg::QCNT_W'(ps2mct_pkg::QDEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_pkt   = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// Store pushed packets
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_pkt;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/ps2mct_back.sv -----
// Cursor update stage: checks the jump limit, moves and clamps the cursor,
// latches buttons and holds the result word in an output register.
// Depends on ps2mct_pkg.
`default_nettype none

module ps2mct_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [ps2mct_pkg::LIMIT_W-1:0]      jump_limit,
	input  wire logic                                pkt_valid,
	input  ps2mct_pkg::pkt_t                         pkt,
	output logic                                     pkt_pop,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [ps2mct_pkg::COORD_W-1:0]           cursor_x,
	output logic [ps2mct_pkg::COORD_W-1:0]           cursor_y,
	output logic [ps2mct_pkg::BUTTON_W-1:0]          button_bits,
	output logic                                     accepted
);

	localparam int SUM_W = ps2mct_pkg::SUM_W;
	localparam int POS_W = ps2mct_pkg::POS_W;
	localparam logic signed [SUM_W-1:0] X_SIZE = SUM_W'(ps2mct_pkg::SCREEN_WIDTH);
	localparam logic signed [SUM_W-1:0] Y_SIZE = SUM_W'(ps2mct_pkg::SCREEN_HEIGHT);

	logic [POS_W-1:0]                    pos_x_q;
	logic [POS_W-1:0]                    pos_y_q;
	logic [ps2mct_pkg::BUTTON_W-1:0]     buttons_q;
	logic                                out_valid_q;
	logic                                accepted_q;

	logic [ps2mct_pkg::BYTE_W-1:0]       mag_x;
	logic [ps2mct_pkg::BYTE_W-1:0]       mag_y;
	logic [ps2mct_pkg::BYTE_W-1:0]       limit_ext;
	logic                                ok;
	logic signed [SUM_W-1:0]             sum_x;
	logic signed [SUM_W-1:0]             sum_y;
	logic [POS_W-1:0]                    next_x;
	logic [POS_W-1:0]                    next_y;

	// Take a packet when the output register is free or being drained
	assign pkt_pop = pkt_valid && (!out_valid_q || out_ready);

	// Jump check on magnitudes; minus 128 yields 128 and always fails
	always_comb begin
		mag_x     = pkt.dx[ps2mct_pkg::BYTE_W-1] ? (~pkt.dx + 1'b1) : pkt.dx;
		mag_y     = pkt.dy[ps2mct_pkg::BYTE_W-1] ? (~pkt.dy + 1'b1) : pkt.dy;
		limit_ext = ps2mct_pkg::BYTE_W'(jump_limit);
		ok        = (mag_x <= limit_ext) && (mag_y <= limit_ext);
	end

	// Move and clamp both axes; the row moves against dy
	always_comb begin
		sum_x = $signed({{(SUM_W-POS_W){1'b0}}, pos_x_q}) + SUM_W'(pkt.dx);
		sum_y = $signed({{(SUM_W-POS_W){1'b0}}, pos_y_q}) - SUM_W'(pkt.dy);
		if (sum_x < 0) begin
			next_x = '0;
		end else if (sum_x >= X_SIZE) begin
			next_x = POS_W'(X_SIZE - 1);
		end else begin
			next_x = sum_x[POS_W-1:0];
		end
		if (sum_y < 0) begin
			next_y = '0;
		end else if (sum_y >= Y_SIZE) begin
			next_y = POS_W'(Y_SIZE - 1);
		end else begin
			next_y = sum_y[POS_W-1:0];
		end
	end

	// Hold cursor state and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= ps2mct_pkg::POS_X_RESET;
			pos_y_q     <= ps2mct_pkg::POS_Y_RESET;
			buttons_q   <= '0;
			out_valid_q <= 1'b0;
			accepted_q  <= 1'b0;
		end else begin
			if (pkt_pop) begin
				out_valid_q <= 1'b1;
				accepted_q  <= ok;
				if (ok) begin
					pos_x_q   <= next_x;
					pos_y_q   <= next_y;
					buttons_q <= pkt.buttons;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign cursor_x    = ps2mct_pkg::COORD_W'(pos_x_q);
	assign cursor_y    = ps2mct_pkg::COORD_W'(pos_y_q);
	assign button_bits = buttons_q;
	assign accepted    = accepted_q;

endmodule

`default_nettype wire

// ----- rtl/core/ps2_mouse_cursor_tracker_unit.sv -----
// PS/2 mouse cursor tracker, top level. A completed packet is written into the
// packet queue, then registered in the update stage's output register.
// Throughput: one byte per cycle while the two-entry packet queue has room.
// Reset (arst_n, asynchronous): jump limit 50, cursor at screen center,
// buttons released, byte tracking waits for a first byte. Depends on ps2mct_pkg.
`default_nettype none

module ps2_mouse_cursor_tracker_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Input stream
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	input  wire logic [ps2mct_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
	// Result stream
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	// [9:0] cursor_x, [19:10] cursor_y, [22:20] button_bits, [23] zero
	output logic [ps2mct_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
	output logic                                        m_axis_tuser,  // [0] accepted
	// Configuration write
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [ps2mct_pkg::LIMIT_W-1:0]         cfg_data       // jump_limit
);

	logic [ps2mct_pkg::LIMIT_W-1:0]      jump_limit_q;
	logic                                byte_valid;
	ps2mct_pkg::pkt_t                    front_pkt;
	logic                                front_push;
	logic                                q_full;
	logic                                q_valid;
	logic                                q_pop;
	ps2mct_pkg::pkt_t                    q_pkt;
	logic [ps2mct_pkg::COORD_W-1:0]      cursor_x;
	logic [ps2mct_pkg::COORD_W-1:0]      cursor_y;
	logic [ps2mct_pkg::BUTTON_W-1:0]     button_bits;
	logic                                accepted;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_limit_q <= ps2mct_pkg::JUMP_LIMIT_RESET;
		end else if (cfg_valid) begin
			jump_limit_q <= cfg_data;
		end
	end

	// Take words while the queue has room
	assign s_axis_tready = !q_full;
	assign byte_valid    = s_axis_tvalid && !q_full;

	ps2mct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_data  (s_axis_tdata),
		.pkt        (front_pkt),
		.pkt_push   (front_push)
	);

	ps2mct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_push),
		.push_pkt  (front_pkt),
		.full      (q_full),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_pkt   (q_pkt)
	);

	ps2mct_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.jump_limit  (jump_limit_q),
		.pkt_valid   (q_valid),
		.pkt         (q_pkt),
		.pkt_pop     (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.cursor_x    (cursor_x),
		.cursor_y    (cursor_y),
		.button_bits (button_bits),
		.accepted    (accepted)
	);

	// Pack the result word
	assign m_axis_tdata = {1'b0, button_bits, cursor_y, cursor_x};
	assign m_axis_tuser = accepted;

endmodule

`default_nettype wire

// ----- dv/tb_ps2_mouse_cursor_tracker_unit.sv -----
// Testbench for ps2_mouse_cursor_tracker_unit: feeds mouse bytes, tracks the cursor
// in a local packet model and checks every result word in order.
// Depends on ps2mct_pkg and the tracker RTL.
module tb_ps2_mouse_cursor_tracker_unit;

	localparam int CYCLE_LIMIT         = 300000;
	localparam int SETTLE_CYCLES       = 8;
	localparam int JUMP_LIMIT_AT_RESET = 50;
	localparam int PHASE_BYTES         = 160;

	// Expected result word
	typedef struct packed {
		logic [ps2mct_pkg::COORD_W-1:0]  x;
		logic [ps2mct_pkg::COORD_W-1:0]  y;
		logic [ps2mct_pkg::BUTTON_W-1:0] buttons;
		logic                            ok;
	} cursor_t;

	// Per-byte tag: a pinned expectation replaces the computed one
	typedef struct packed {
		logic    pinned;
		cursor_t want;
	} pin_t;

	typedef enum logic [1:0] {WAIT_HEAD, WAIT_DX, WAIT_DY} packet_phase_t;
	typedef enum logic {ROW_BYTE, ROW_LIMIT} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [7:0]  val;
		logic        pinned;
		cursor_t     want;
	} stim_row_t;

	// Directed rows: drops, extremes, rejects, limit extremes
	localparam stim_row_t DIRECTED [28] = '{
		'{ROW_BYTE,  8'h00, 1'b0, '0},
		'{ROW_BYTE,  8'hF7, 1'b0, '0},
		'{ROW_BYTE,  8'h08, 1'b0, '0},
		'{ROW_BYTE,  8'h00, 1'b0, '0},
		'{ROW_BYTE,  8'h00, 1'b1, '{10'd512, 10'd384, 3'd0, 1'b1}},
		'{ROW_BYTE,  8'hFF, 1'b0, '0},
		'{ROW_BYTE,  8'h80, 1'b0, '0},
		'{ROW_BYTE,  8'h00, 1'b1, '{10'd512, 10'd384, 3'd0, 1'b0}},
		'{ROW_BYTE,  8'h0D, 1'b0, '0},
		'{ROW_BYTE,  8'h32, 1'b0, '0},
		'{ROW_BYTE,  8'hCE, 1'b1, '{10'd562, 10'd434, 3'd5, 1'b1}},
		'{ROW_BYTE,  8'h09, 1'b0, '0},
		'{ROW_BYTE,  8'h33, 1'b0, '0},
		'{ROW_BYTE,  8'h00, 1'b1, '{10'd562, 10'd434, 3'd5, 1'b0}},
		'{ROW_LIMIT, 8'd127, 1'b0, '0},
		'{ROW_BYTE,  8'h0A, 1'b0, '0},
		'{ROW_BYTE,  8'h7F, 1'b0, '0},
		'{ROW_BYTE,  8'h81, 1'b0, '0},
		'{ROW_BYTE,  8'h08, 1'b0, '0},
		'{ROW_BYTE,  8'h80, 1'b0, '0},
		'{ROW_BYTE,  8'h80, 1'b0, '0},
		'{ROW_LIMIT, 8'd0,  1'b0, '0},
		'{ROW_BYTE,  8'h0C, 1'b0, '0},
		'{ROW_BYTE,  8'h00, 1'b0, '0},
		'{ROW_BYTE,  8'h00, 1'b0, '0},
		'{ROW_BYTE,  8'h08, 1'b0, '0},
		'{ROW_BYTE,  8'h01, 1'b0, '0},
		'{ROW_BYTE,  8'h00, 1'b0, '0}
	};

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_axis_tvalid = 1'b0;
	logic                              s_axis_tready;
	logic [ps2mct_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                              m_axis_tvalid;
	logic                              m_axis_tready = 1'b0;
	logic [ps2mct_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                              m_axis_tuser;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [ps2mct_pkg::LIMIT_W-1:0]    cfg_data = '0;

	// Cursor model state
	packet_phase_t                     byte_phase = WAIT_HEAD;
	logic [7:0]                        head_byte = '0;
	logic [7:0]                        dx_byte = '0;
	int                                cur_x = ps2mct_pkg::SCREEN_WIDTH / 2;
	int                                cur_y = ps2mct_pkg::SCREEN_HEIGHT / 2;
	logic [ps2mct_pkg::BUTTON_W-1:0]   held_buttons = '0;
	logic [ps2mct_pkg::LIMIT_W-1:0]    limit_reg =
		ps2mct_pkg::LIMIT_W'(JUMP_LIMIT_AT_RESET);

	cursor_t               cursor_q[$];
	pin_t                  pin_q[$];
	int                    err_count = 0;
	int                    cycle_count = 0;
	int                    stall_left = 0;
	bit                    idle_on = 1'b1;

	ps2_mouse_cursor_tracker_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int clip_axis(int v, int span);
		if (v < 0)
			return 0;
		if (v >= span)
			return span - 1;
		return v;
	endfunction

	// Advance the packet model by one mouse byte; queue a result on the third byte
	function automatic void track_byte(logic [7:0] b, pin_t pin);
		int      dx;
		int      dy;
		int      lim;
		bit      ok;
		cursor_t res;
		case (byte_phase)
			WAIT_HEAD: begin
				if (b[ps2mct_pkg::SYNC_BIT]) begin
					head_byte = b;
					byte_phase = WAIT_DX;
				end
			end
			WAIT_DX: begin
				dx_byte = b;
				byte_phase = WAIT_DY;
			end
			default: begin
				byte_phase = WAIT_HEAD;
				dx = $signed(dx_byte);
				dy = $signed(b);
				lim = int'(limit_reg);
				ok = (dx >= -lim) && (dx <= lim) && (dy >= -lim) && (dy <= lim);
				if (ok) begin
					cur_x = clip_axis(cur_x + dx, ps2mct_pkg::SCREEN_WIDTH);
					cur_y = clip_axis(cur_y - dy, ps2mct_pkg::SCREEN_HEIGHT);
					held_buttons = head_byte[ps2mct_pkg::BUTTON_W-1:0];
				end
				res.x = ps2mct_pkg::COORD_W'(cur_x);
				res.y = ps2mct_pkg::COORD_W'(cur_y);
				res.buttons = held_buttons;
				res.ok = ok;
				cursor_q.push_back(pin.pinned ? pin.want : res);
			end
		endcase
	endfunction

	// Delta byte: mostly inside the limit, often on or just past it, some extremes
	function automatic logic [7:0] pick_delta(int lim, int neg_pct);
		int sel;
		int mag;
		int v;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			mag = $urandom_range(0, lim);
		else if (sel < 70)
			mag = lim;
		else if (sel < 80)
			mag = lim + 1;
		else if (sel < 88)
			mag = $urandom_range(0, 1) ? 128 : 127;
		else
			return 8'($urandom_range(0, 255));
		v = (mag == 128 || $urandom_range(0, 99) < neg_pct) ? -mag : mag;
		return v[7:0];
	endfunction

	// Send one word on the input stream, with an optional idle burst first
	task automatic send_word(logic [7:0] b, logic pinned, cursor_t want);
		if (idle_on && $urandom_range(0, 99) < 20) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		pin_q.push_back('{pinned, want});
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Hold the sender until every expected word is back, then let the pipe drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (cursor_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [ps2mct_pkg::LIMIT_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random output stalls in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 99) < 20) begin
			stall_left <= $urandom_range(0, 7);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Observe config and input words, then check result words
	always @(posedge clk) begin : watch
		pin_t    pin;
		cursor_t want;
		if (cfg_valid && cfg_ready)
			limit_reg = cfg_data;
		if (s_axis_tvalid && s_axis_tready) begin
			pin = pin_q.pop_front();
			track_byte(s_axis_tdata, pin);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (cursor_q.size() == 0) begin
				$error("result word with nothing expected: tdata %h tuser %b",
					m_axis_tdata, m_axis_tuser);
				err_count++;
			end else begin
				want = cursor_q.pop_front();
				if (m_axis_tdata[9:0] !== want.x) begin
					$error("cursor_x: expected %0d, got %0d", want.x, m_axis_tdata[9:0]);
					err_count++;
				end
				if (m_axis_tdata[19:10] !== want.y) begin
					$error("cursor_y: expected %0d, got %0d", want.y, m_axis_tdata[19:10]);
					err_count++;
				end
				if (m_axis_tdata[22:20] !== want.buttons) begin
					$error("button_bits: expected %0d, got %0d", want.buttons,
						m_axis_tdata[22:20]);
					err_count++;
				end
				if (m_axis_tuser !== want.ok) begin
					$error("accepted: expected %0d, got %0d", want.ok, m_axis_tuser);
					err_count++;
				end
				if (m_axis_tdata[23] !== 1'b0) begin
					$error("pad: expected 0, got %b", m_axis_tdata[23]);
					err_count++;
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_ps2_mouse_cursor_tracker_unit: errors");
			$finish;
		end
	end

	initial begin : stimulus
		int         lim;
		int         sent;
		int         neg_x;
		int         neg_y;
		bit         flipped;
		logic [7:0] head;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_LIMIT) begin
				settle();
				write_limit(DIRECTED[i].val[ps2mct_pkg::LIMIT_W-1:0]);
			end else begin
				send_word(DIRECTED[i].val, DIRECTED[i].pinned, DIRECTED[i].want);
			end
		end

		// Random phases, each under its own jump limit; phases 2 and 5 have no idling
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: lim = 127;
				1: lim = 0;
				2: lim = $urandom_range(2, 125);
				3: lim = 1;
				4: lim = 126;
				default: lim = $urandom_range(2, 125);
			endcase
			settle();
			write_limit(ps2mct_pkg::LIMIT_W'(lim));
			idle_on = (ph != 2) && (ph != 5);
			neg_x = $urandom_range(0, 1) ? 80 : 20;
			neg_y = $urandom_range(0, 1) ? 80 : 20;
			flipped = 1'b0;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				// Reverse the drift halfway so both screen edges get hit
				if (sent >= PHASE_BYTES / 2 && !flipped) begin
					flipped = 1'b1;
					neg_x = 100 - neg_x;
					neg_y = 100 - neg_y;
					if (ph == 3)
						settle();
				end
				if ($urandom_range(0, 99) < 10) begin
					send_word(8'($urandom_range(0, 255)), 1'b0, '0);
					sent++;
				end else begin
					head = 8'($urandom_range(0, 255));
					head[ps2mct_pkg::SYNC_BIT] = 1'b1;
					send_word(head, 1'b0, '0);
					send_word(pick_delta(lim, neg_x), 1'b0, '0);
					send_word(pick_delta(lim, neg_y), 1'b0, '0);
					sent += 3;
				end
			end
		end

		settle();
		if (err_count == 0)
			$display("tb_ps2_mouse_cursor_tracker_unit: clean");
		else
			$display("tb_ps2_mouse_cursor_tracker_unit: errors");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/ps2mct_pkg.sv
rtl/core/ps2mct_front.sv
rtl/core/ps2mct_queue.sv
rtl/core/ps2mct_back.sv
rtl/core/ps2_mouse_cursor_tracker_unit.sv
dv/tb_ps2_mouse_cursor_tracker_unit.sv
